// ----- src/rfc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rfc_pkg
// Shared types, constants and tables of the RMS feed-forward compressor.
// ----------------------------------------------------------------------------
package rfc_pkg;

  localparam int SAMPLE_W = 16;
  localparam int RATIO_M1 = 3;

  localparam int MAG_W    = SAMPLE_W + 1;
  localparam int SQ_LSH   = (2 * SAMPLE_W <= 34) ? 34 - 2 * SAMPLE_W : 0;
  localparam int SQ_RSH   = (2 * SAMPLE_W <= 34) ? 0 : 2 * SAMPLE_W - 34;
  localparam int REG_W    = 24;
  localparam int ADDR_W   = 5;
  localparam int ENV_W    = 23;
  localparam int LG_W     = 19;
  localparam int ROOT_W   = 24;
  localparam int RAD_W    = 48;
  localparam int SREM_W   = 26;
  localparam int C_W      = 24 + $clog2(RATIO_M1 + 1);
  localparam int D_W      = C_W + 1;
  localparam int NUM_W    = ENV_W + C_W + 1;
  localparam int G_W      = 25;
  localparam int Y_W      = MAG_W + G_W - 16;
  localparam int CNT_W    = 5;

  localparam int SQRT_STEPS = 24;
  localparam int LOG_STEPS  = 16;
  localparam int DIV_STEPS  = 24;
  localparam int EXP_STEPS  = 16;

  localparam logic [ENV_W-1:0] DB_MAX   = '1;
  localparam logic [23:0]      LN2_Q24  = 24'd11629080;
  localparam logic [23:0]      L2T_Q24  = 24'd2786635;
  localparam logic [24:0]      ONE_Q24  = 25'h1000000;
  localparam logic [63:0]      HALF_Q24 = 64'h800000;
  localparam logic [Y_W-1:0]   POS_MAX  = Y_W'((64'd1 << (SAMPLE_W - 1)) - 64'd1);

  localparam logic [REG_W-1:0] THR_RST    = 24'd92572;
  localparam logic [REG_W-1:0] BIAS_RST   = 24'd1170;
  localparam logic [REG_W-1:0] MAKEUP_RST = 24'd65536;
  localparam logic [REG_W-1:0] DBS_RST    = 24'd569239;
  localparam logic [REG_W-1:0] ATK_RST    = 24'd14978900;
  localparam logic [REG_W-1:0] REL_RST    = 24'd16775948;
  localparam logic [REG_W-1:0] RMS_RST    = 24'd13373290;

  typedef enum logic [2:0] {
    REG_THR, REG_BIAS, REG_MAKEUP, REG_DBS, REG_ATK, REG_REL, REG_RMS
  } reg_idx_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_MS_A, OP_MS_B, OP_SQRT, OP_LVL, OP_NORM, OP_LOG,
    OP_LN, OP_OVR, OP_ENV_A, OP_ENV_B, OP_BIAS, OP_DIVSET, OP_DIV, OP_T,
    OP_EXP, OP_TOT, OP_GAIN, OP_OUT
  } op_e;

  typedef enum logic [4:0] {
    S_IDLE, S_MS_A, S_MS_B, S_SQRT_LVL, S_LVL, S_NORM, S_LOG, S_LN, S_OVR,
    S_ENV_A, S_ENV_B, S_BIAS, S_SQRT_RAT, S_DIVSET, S_DIV, S_T, S_EXP,
    S_TOT, S_GAIN, S_FIN
  } state_e;

  typedef struct packed {
    op_e              op;
    logic [CNT_W-1:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic lvl_small;
  } status_t;

  typedef struct packed {
    logic [REG_W-1:0] threshold_recip;
    logic [REG_W-1:0] bias_recip;
    logic [REG_W-1:0] makeup_gain;
    logic [REG_W-1:0] db_scale;
    logic [REG_W-1:0] attack_coef;
    logic [REG_W-1:0] release_coef;
    logic [REG_W-1:0] rms_coef;
  } cfg_t;

  typedef logic [16:0][30:0] pow_tab_t;

  function automatic logic [63:0] isqrt_f(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    int          i;
    v   = v_in;
    res = '0;
    b   = 64'h4000000000000000;
    for (i = 0; i < 32; i++) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Factors 2^-(2^-j) in Q1.30 for j = 1..16, each from j = 2 on a square root of the one before; entry 0 is 1.0.
  function automatic pow_tab_t pow_table();
    pow_tab_t    t;
    logic [63:0] p;
    int          k;
    t[0] = 31'h40000000;
    p    = isqrt_f(64'h0800000000000000);
    t[1] = p[30:0];
    for (k = 2; k <= 16; k++) begin
      p    = isqrt_f(p << 30);
      t[k] = p[30:0];
    end
    return t;
  endfunction

  localparam pow_tab_t POW_TAB = pow_table();

endpackage
`default_nettype wire

// ----- src/rms_feedforward_compressor.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rms_feedforward_compressor
// Feed-forward RMS compressor: level detect, dB overshoot, smoothed gain
// reduction with program-dependent ratio, exp gain and makeup.
// ----------------------------------------------------------------------------
// One sample is processed at a time. When the level stays below threshold
// the log stage is skipped. The work is done by the bit-serial square root
// (24 steps, run twice), the 24-step divider for the ratio and the 16-step
// log2 and exp loops; the log2 and exp loops share one 32x32 multiplier with
// the other multiply steps. A finished result sits in an output register,
// so the next sample is taken while it waits.
// Settings sit on an APB port at byte address 4*i and should be written
// while the block is idle.
module rms_feedforward_compressor (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rfc_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [15:0]                 sample_in_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [15:0]                 sample_out_o,
  output logic [23:0]                 gain_reduction_o
);
  import rfc_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  rfc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rfc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rfc_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .cfg_i            (cfg),
    .sample_in_i      (sample_in_i),
    .status_o         (status),
    .sample_out_o     (sample_out_o),
    .gain_reduction_o (gain_reduction_o)
  );

endmodule
`default_nettype wire

// ----- src/rfc_regs.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rfc_regs
// APB register file holding the compressor settings.
// ----------------------------------------------------------------------------
module rfc_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rfc_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output rfc_pkg::cfg_t               cfg_o
);
  import rfc_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_THR:    cfg_d.threshold_recip = pwdata[REG_W-1:0];
        REG_BIAS:   cfg_d.bias_recip      = pwdata[REG_W-1:0];
        REG_MAKEUP: cfg_d.makeup_gain     = pwdata[REG_W-1:0];
        REG_DBS:    cfg_d.db_scale        = pwdata[REG_W-1:0];
        REG_ATK:    cfg_d.attack_coef     = pwdata[REG_W-1:0];
        REG_REL:    cfg_d.release_coef    = pwdata[REG_W-1:0];
        REG_RMS:    cfg_d.rms_coef        = pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_THR:    prdata = 32'(cfg_q.threshold_recip);
      REG_BIAS:   prdata = 32'(cfg_q.bias_recip);
      REG_MAKEUP: prdata = 32'(cfg_q.makeup_gain);
      REG_DBS:    prdata = 32'(cfg_q.db_scale);
      REG_ATK:    prdata = 32'(cfg_q.attack_coef);
      REG_REL:    prdata = 32'(cfg_q.release_coef);
      REG_RMS:    prdata = 32'(cfg_q.rms_coef);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold_recip <= THR_RST;
      cfg_q.bias_recip      <= BIAS_RST;
      cfg_q.makeup_gain     <= MAKEUP_RST;
      cfg_q.db_scale        <= DBS_RST;
      cfg_q.attack_coef     <= ATK_RST;
      cfg_q.release_coef    <= REL_RST;
      cfg_q.rms_coef        <= RMS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

// ----- src/rfc_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rfc_ctrl
// Sequencer: steps the datapath through one sample and runs the handshakes.
// ----------------------------------------------------------------------------
module rfc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  rfc_pkg::status_t   status_i,
  output rfc_pkg::cmd_t      cmd_o
);
  import rfc_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             can_load;

  assign can_load    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:     if (in_valid_i) state_d = S_MS_A;
      S_MS_A:     state_d = S_MS_B;
      S_MS_B:     state_d = S_SQRT_LVL;
      S_SQRT_LVL: if (cnt_q == CNT_W'(SQRT_STEPS - 1)) state_d = S_LVL;
      S_LVL:      state_d = S_NORM;
      S_NORM:     state_d = status_i.lvl_small ? S_ENV_A : S_LOG;
      S_LOG:      if (cnt_q == CNT_W'(LOG_STEPS - 1)) state_d = S_LN;
      S_LN:       state_d = S_OVR;
      S_OVR:      state_d = S_ENV_A;
      S_ENV_A:    state_d = S_ENV_B;
      S_ENV_B:    state_d = S_BIAS;
      S_BIAS:     state_d = S_SQRT_RAT;
      S_SQRT_RAT: if (cnt_q == CNT_W'(SQRT_STEPS - 1)) state_d = S_DIVSET;
      S_DIVSET:   state_d = S_DIV;
      S_DIV:      if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = S_T;
      S_T:        state_d = S_EXP;
      S_EXP:      if (cnt_q == CNT_W'(EXP_STEPS - 1)) state_d = S_TOT;
      S_TOT:      state_d = S_GAIN;
      S_GAIN:     state_d = S_FIN;
      S_FIN:      if (can_load) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cnt_d = (state_d != state_q) ? '0 : cnt_q + CNT_W'(1);
    out_valid_d = out_valid_q;
    if (state_q == S_FIN && can_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_comb begin
    in_stall_o = (state_q != S_IDLE);
    cmd_o.cnt  = cnt_q;
    case (state_q)
      S_IDLE:     cmd_o.op = in_valid_i ? OP_LOAD : OP_NONE;
      S_MS_A:     cmd_o.op = OP_MS_A;
      S_MS_B:     cmd_o.op = OP_MS_B;
      S_SQRT_LVL: cmd_o.op = OP_SQRT;
      S_LVL:      cmd_o.op = OP_LVL;
      S_NORM:     cmd_o.op = OP_NORM;
      S_LOG:      cmd_o.op = OP_LOG;
      S_LN:       cmd_o.op = OP_LN;
      S_OVR:      cmd_o.op = OP_OVR;
      S_ENV_A:    cmd_o.op = OP_ENV_A;
      S_ENV_B:    cmd_o.op = OP_ENV_B;
      S_BIAS:     cmd_o.op = OP_BIAS;
      S_SQRT_RAT: cmd_o.op = OP_SQRT;
      S_DIVSET:   cmd_o.op = OP_DIVSET;
      S_DIV:      cmd_o.op = OP_DIV;
      S_T:        cmd_o.op = OP_T;
      S_EXP:      cmd_o.op = OP_EXP;
      S_TOT:      cmd_o.op = OP_TOT;
      S_GAIN:     cmd_o.op = OP_GAIN;
      S_FIN:      cmd_o.op = can_load ? OP_OUT : OP_NONE;
      default:    cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

// ----- src/rfc_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rfc_dp
// Datapath: one shared 32x32 multiplier, bit-serial square root and divider,
// log2 by repeated squaring, exp by a product over a constant table.
// ----------------------------------------------------------------------------
module rfc_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rfc_pkg::cmd_t     cmd_i,
  input  rfc_pkg::cfg_t     cfg_i,
  input  logic [15:0]       sample_in_i,
  output rfc_pkg::status_t  status_o,
  output logic [15:0]       sample_out_o,
  output logic [23:0]       gain_reduction_o
);
  import rfc_pkg::*;

  logic [MAG_W-1:0]  mag_q, mag_d;
  logic              neg_q, neg_d;
  logic [31:0]       ms_q, ms_d;
  logic [31:0]       sq_q, sq_d;
  logic [ENV_W-1:0]  env_q, env_d;
  logic [63:0]       acc_q, acc_d;
  logic [RAD_W-1:0]  rad_q, rad_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [SREM_W-1:0] srem_q, srem_d;
  logic [D_W-1:0]    drem_q, drem_d;
  logic [D_W-1:0]    d_q, d_d;
  logic [31:0]       mant_q, mant_d;
  logic [LG_W-1:0]   lg_q, lg_d;
  logic [ENV_W-1:0]  ovr_q, ovr_d;
  logic [ENV_W-1:0]  m_q, m_d;
  logic [15:0]       f_q, f_d;
  logic [4:0]        n_q, n_d;
  logic [30:0]       r_q, r_d;
  logic [G_W-1:0]    g_q, g_d;
  logic [15:0]       so_q, so_d;
  logic [23:0]       gr_q, gr_d;

  logic [31:0]         mul_a, mul_b;
  logic [63:0]         prod;
  logic [SAMPLE_W-1:0] raw;
  logic [63:0]         sq_full;
  logic [31:0]         sq;
  logic [REG_W-1:0]    k_sel;
  logic [ENV_W-1:0]    m_lim;
  logic [C_W-1:0]      c_val;
  logic [4:0]          exp_i;
  logic                f_bit;
  logic [2:0]          hi_idx;
  logic [SREM_W+1:0]   sq_cur, sq_trial;
  logic [D_W:0]        div_cur;
  logic [NUM_W-1:0]    num;
  logic [63:0]         sum;
  logic [32:0]         mm;
  logic [5:0]          sh;
  logic [63:0]         rnd;
  logic [Y_W-1:0]      y, ysat;

  assign raw = sample_in_i[SAMPLE_W-1:0];

  always_comb begin
    sq_full = ((64'(mag_q) * 64'(mag_q)) << SQ_LSH) >> SQ_RSH;
    sq      = (sq_full > 64'hFFFFFFFF) ? 32'hFFFFFFFF : sq_full[31:0];
    k_sel   = (env_q < ovr_q) ? cfg_i.attack_coef : cfg_i.release_coef;
    m_lim   = (root_q > ROOT_W'(DB_MAX)) ? DB_MAX : root_q[ENV_W-1:0];
    c_val   = C_W'(C_W'(root_q) * C_W'(RATIO_M1));
    exp_i   = 5'(cmd_i.cnt[3:0]) + 5'd1;
    f_bit   = f_q[4'd15 - cmd_i.cnt[3:0]];
    hi_idx  = '0;
    for (int i = 0; i < 8; i++) begin
      if (acc_q[32+i]) hi_idx = 3'(i);
    end
  end

  assign status_o.lvl_small = (acc_q[39:32] == 8'd0);

  always_comb begin
    case (cmd_i.op)
      OP_MS_A:   begin mul_a = ms_q;                 mul_b = 32'(cfg_i.rms_coef); end
      OP_MS_B:   begin mul_a = sq_q;
                       mul_b = 32'(ONE_Q24 - 25'(cfg_i.rms_coef)); end
      OP_LVL:    begin mul_a = 32'(root_q[15:0]);    mul_b = 32'(cfg_i.threshold_recip); end
      OP_LOG:    begin mul_a = mant_q;               mul_b = mant_q; end
      OP_LN:     begin mul_a = 32'(lg_q);            mul_b = 32'(LN2_Q24); end
      OP_OVR:    begin mul_a = 32'(cfg_i.db_scale);  mul_b = 32'(lg_q); end
      OP_ENV_A:  begin mul_a = 32'(ovr_q);           mul_b = 32'(ONE_Q24 - 25'(k_sel)); end
      OP_ENV_B:  begin mul_a = 32'(env_q);           mul_b = 32'(k_sel); end
      OP_BIAS:   begin mul_a = 32'(env_q);           mul_b = 32'(cfg_i.bias_recip); end
      OP_DIVSET: begin mul_a = 32'(env_q);           mul_b = 32'(c_val); end
      OP_T:      begin mul_a = 32'(m_lim);           mul_b = 32'(L2T_Q24); end
      OP_EXP:    begin mul_a = 32'(r_q);             mul_b = 32'(POW_TAB[exp_i]); end
      OP_TOT:    begin mul_a = 32'(r_q);             mul_b = 32'(cfg_i.makeup_gain); end
      OP_OUT:    begin mul_a = 32'(mag_q);           mul_b = 32'(g_q); end
      default:   begin mul_a = '0;                   mul_b = '0; end
    endcase
  end

  assign prod = 64'(mul_a) * 64'(mul_b);

  always_comb begin
    mag_d  = mag_q;  neg_d  = neg_q;  ms_d   = ms_q;   env_d = env_q;
    acc_d  = acc_q;  rad_d  = rad_q;  root_d = root_q; srem_d = srem_q;
    drem_d = drem_q; d_d    = d_q;    mant_d = mant_q; lg_d  = lg_q;
    ovr_d  = ovr_q;  m_d    = m_q;    f_d    = f_q;    n_d   = n_q;
    r_d    = r_q;    g_d    = g_q;    so_d   = so_q;   gr_d  = gr_q;
    sq_d   = sq_q;
    sum      = '0;
    sq_cur   = '0;
    sq_trial = '0;
    div_cur  = '0;
    num      = '0;
    mm       = '0;
    sh       = '0;
    rnd      = '0;
    y        = '0;
    ysat     = '0;
    case (cmd_i.op)
      OP_LOAD: begin
        neg_d = raw[SAMPLE_W-1];
        mag_d = raw[SAMPLE_W-1] ? (MAG_W'(1) << SAMPLE_W) - {1'b0, raw} : {1'b0, raw};
      end
      OP_MS_A: begin
        acc_d = prod;
        sq_d  = sq;
      end
      OP_LVL, OP_ENV_A, OP_TOT: begin
        acc_d = prod;
      end
      OP_MS_B: begin
        sum    = acc_q + prod + HALF_Q24;
        ms_d   = sum[55:24];
        rad_d  = RAD_W'(sum[55:24]);
        root_d = '0;
        srem_d = '0;
      end
      OP_SQRT: begin
        sq_cur   = {srem_q, rad_q[RAD_W-1 -: 2]};
        sq_trial = {2'b00, root_q, 2'b01};
        if (sq_cur >= sq_trial) begin
          srem_d = SREM_W'(sq_cur - sq_trial);
          root_d = {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          srem_d = sq_cur[SREM_W-1:0];
          root_d = {root_q[ROOT_W-2:0], 1'b0};
        end
        rad_d = {rad_q[RAD_W-3:0], 2'b00};
      end
      OP_NORM: begin
        ovr_d  = '0;
        lg_d   = {hi_idx, 16'd0};
        mant_d = 32'(acc_q[39:0] >> ({1'b0, hi_idx} + 4'd1));
      end
      OP_LOG: begin
        mm = prod[63:31];
        if (mm[32]) begin
          mant_d = mm[32:1];
          lg_d   = {lg_q[18:16], lg_q[14:0], 1'b1};
        end else begin
          mant_d = mm[31:0];
          lg_d   = {lg_q[18:16], lg_q[14:0], 1'b0};
        end
      end
      OP_LN: begin
        sum  = prod + HALF_Q24;
        lg_d = sum[24 +: LG_W];
      end
      OP_OVR: begin
        sum   = prod + 64'd32768;
        ovr_d = (sum[63:16] > 48'(DB_MAX)) ? DB_MAX : sum[16 +: ENV_W];
      end
      OP_ENV_B: begin
        sum   = acc_q + prod + HALF_Q24;
        env_d = sum[24 +: ENV_W];
      end
      OP_BIAS: begin
        rad_d  = prod[RAD_W-1:0];
        root_d = '0;
        srem_d = '0;
      end
      OP_DIVSET: begin
        d_d    = D_W'(c_val) + D_W'(65536);
        num    = NUM_W'(prod) + NUM_W'(d_d >> 1);
        drem_d = D_W'(num[NUM_W-1:24]);
        rad_d  = {num[23:0], 24'd0};
        root_d = '0;
      end
      OP_DIV: begin
        div_cur = {drem_q, rad_q[RAD_W-1]};
        if (div_cur >= {1'b0, d_q}) begin
          drem_d = D_W'(div_cur - {1'b0, d_q});
          root_d = {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          drem_d = div_cur[D_W-1:0];
          root_d = {root_q[ROOT_W-2:0], 1'b0};
        end
        rad_d = {rad_q[RAD_W-2:0], 1'b0};
      end
      OP_T: begin
        m_d = m_lim;
        sum = prod + HALF_Q24;
        f_d = sum[39:24];
        n_d = sum[44:40];
        r_d = 31'h40000000;
      end
      OP_EXP: begin
        if (f_bit) begin
          sum = prod + (64'd1 << 29);
          r_d = sum[60:30];
        end
      end
      OP_GAIN: begin
        if (n_q == 5'd31) begin
          g_d = '0;
        end else begin
          sh  = 6'd30 + 6'(n_q);
          rnd = 64'd1 << (sh - 6'd1);
          sum = acc_q + rnd;
          g_d = G_W'(sum >> sh);
        end
      end
      OP_OUT: begin
        y = prod[16 +: Y_W];
        if (neg_q) begin
          ysat = (y > POS_MAX + Y_W'(1)) ? POS_MAX + Y_W'(1) : y;
          so_d = 16'(Y_W'(0) - ysat);
        end else begin
          ysat = (y > POS_MAX) ? POS_MAX : y;
          so_d = 16'(ysat);
        end
        gr_d = 24'd0 - 24'(m_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_q  <= '0;
      env_q <= '0;
    end else begin
      ms_q  <= ms_d;
      env_q <= env_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;  neg_q  <= neg_d;  acc_q  <= acc_d;  rad_q <= rad_d;
    root_q <= root_d; srem_q <= srem_d; drem_q <= drem_d; d_q   <= d_d;
    mant_q <= mant_d; lg_q   <= lg_d;   ovr_q  <= ovr_d;  m_q   <= m_d;
    f_q    <= f_d;    n_q    <= n_d;    r_q    <= r_d;    g_q   <= g_d;
    so_q   <= so_d;   gr_q   <= gr_d;   sq_q   <= sq_d;
  end

  assign sample_out_o     = so_q;
  assign gain_reduction_o = gr_q;

endmodule
`default_nettype wire
